FILE: hdl/cda_pkg.sv
// Shared types, constants and calendar helper functions for the calendar date advance core.
// Used by the datapath, the controller, the mod-400 unit and the port checker.
// No dependencies.
package cda_pkg;

	// Default widths of the year and the day count.
	localparam int YEAR_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 20;

	// Fixed field widths.
	localparam int MON_W    = 4;
	localparam int DAY_W    = 5;
	localparam int STATUS_W = 2;
	localparam int MOD_W    = 9;  // holds a year modulo 400

	// Calendar constants.
	localparam int YEAR_CYCLE     = 400;
	localparam int CENTURY        = 100;
	localparam int DAYS_LEAP_YEAR = 366;
	localparam int DAYS_YEAR      = 365;
	localparam int FEB_LEAP_DAYS  = 29;
	localparam int FEB_DAYS       = 28;
	localparam int YEAR_LEN_W     = 9;

	localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

	// Command codes.
	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_ADD = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture an accepted transfer
		logic mod_start;  // start the year modulo 400 reduction
		logic set_check;  // validate the candidate date and store it if good
		logic day_step;   // advance the working date by one day
		logic year_step;  // advance the working date by one whole year
		logic commit;     // store the working date, status ok
		logic overflow;   // drop the working date, status overflow
		logic out_load;   // move the stored date and status to the output register
	} cda_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mod_done;   // reduction finishes at this edge
		logic n_zero;     // no days left to add
		logic n_ge_year;  // at least 366 days left
		logic feb29;      // working date is February 29
		logic year_max;   // working year is at its largest value
		logic day_ovf;    // a day step would carry past the largest year
	} cda_stat_t;

	// Leap year test from the year modulo 400.
	function automatic logic leap_of_mod(input logic [MOD_W-1:0] ymod);
		return (ymod[1:0] == 2'b00) &&
			(ymod != MOD_W'(CENTURY)) &&
			(ymod != MOD_W'(2 * CENTURY)) &&
			(ymod != MOD_W'(3 * CENTURY));
	endfunction

	// Year modulo 400 of the following year.
	function automatic logic [MOD_W-1:0] mod_inc(input logic [MOD_W-1:0] ymod);
		return (ymod == MOD_W'(YEAR_CYCLE - 1)) ? '0 : ymod + MOD_W'(1);
	endfunction

	// Length of a month; zero for a month number outside 1 to 12.
	function automatic logic [DAY_W-1:0] month_len(input logic leap,
		input logic [MON_W-1:0] month);
		logic [DAY_W-1:0] len;
		case (month) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2: len = leap ? DAY_W'(FEB_LEAP_DAYS) : DAY_W'(FEB_DAYS);
			default:                                     len = '0;
		endcase
		return len;
	endfunction

endpackage

FILE: hdl/cda_mod400.sv
// Reduction of a year modulo 400 by reciprocal multiplication: the product is registered first, then the remainder.
// Depends on cda_pkg.
module cda_mod400 #(
	parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [YEAR_BITS-1:0]       value,
	output logic                       done,
	output logic [cda_pkg::MOD_W-1:0]  rem
);

	// The year over 400 is the year over 16, divided by 25. The division by 25 is a
	// multiplication by a rounded-up reciprocal that is exact for every value of the width.
	localparam int LOW_BITS = 4;
	localparam int DIVISOR  = cda_pkg::YEAR_CYCLE >> LOW_BITS;
	localparam int XW       = YEAR_BITS - LOW_BITS;
	localparam int SHIFT    = XW + $clog2(DIVISOR);
	localparam int RW       = XW + 1;
	localparam int PW       = XW + RW;
	localparam longint unsigned RECIP_VAL =
		((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_VAL);

	logic                      busy_q;
	logic [PW-1:0]             prod_q;
	logic [cda_pkg::MOD_W-1:0] ylo_q;
	logic [cda_pkg::MOD_W-1:0] rem_q;
	logic [cda_pkg::MOD_W-1:0] quot_lo;

	// The remainder is below 400, so the low bits of the difference are all that is needed.
	assign quot_lo = cda_pkg::MOD_W'(prod_q >> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(value[YEAR_BITS-1:LOW_BITS]) * PW'(RECIP);
			ylo_q  <= value[cda_pkg::MOD_W-1:0];
		end
		if (busy_q) begin
			rem_q <= ylo_q - quot_lo * cda_pkg::MOD_W'(cda_pkg::YEAR_CYCLE);
		end
	end

	assign done = busy_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/cda_dp.sv
// Datapath of the calendar date advance core: stored date, working date, day counter,
// candidate date check and output register. Depends on cda_pkg and cda_mod400.
module cda_dp #(
	parameter int YEAR_BITS  = cda_pkg::YEAR_BITS_DEF,
	parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cda_pkg::cda_cmd_t             ctl,
	output cda_pkg::cda_stat_t            stat,
	input  logic [YEAR_BITS-1:0]          new_year,
	input  logic [cda_pkg::MON_W-1:0]     new_month,
	input  logic [cda_pkg::DAY_W-1:0]     new_day,
	input  logic [COUNT_BITS-1:0]         day_count,
	output logic [YEAR_BITS-1:0]          cur_year,
	output logic [cda_pkg::MON_W-1:0]     cur_month,
	output logic [cda_pkg::DAY_W-1:0]     cur_day,
	output logic [cda_pkg::STATUS_W-1:0]  status
);

	localparam int CMP_W = (COUNT_BITS > cda_pkg::YEAR_LEN_W) ? COUNT_BITS :
		cda_pkg::YEAR_LEN_W;

	// Stored date with its year modulo 400.
	logic [YEAR_BITS-1:0]          date_year_q;
	logic [cda_pkg::MON_W-1:0]     date_mon_q;
	logic [cda_pkg::DAY_W-1:0]     date_day_q;
	logic [cda_pkg::MOD_W-1:0]     date_mod_q;
	// Candidate date of a set command.
	logic [YEAR_BITS-1:0]          cand_year_q;
	logic [cda_pkg::MON_W-1:0]     cand_mon_q;
	logic [cda_pkg::DAY_W-1:0]     cand_day_q;
	// Working date and remaining days of an add command.
	logic [YEAR_BITS-1:0]          w_year_q;
	logic [cda_pkg::MON_W-1:0]     w_mon_q;
	logic [cda_pkg::DAY_W-1:0]     w_day_q;
	logic [cda_pkg::MOD_W-1:0]     w_mod_q;
	logic [COUNT_BITS-1:0]         n_q;
	logic [cda_pkg::STATUS_W-1:0]  res_status_q;
	// Output register.
	logic [YEAR_BITS-1:0]          out_year_q;
	logic [cda_pkg::MON_W-1:0]     out_mon_q;
	logic [cda_pkg::DAY_W-1:0]     out_day_q;
	logic [cda_pkg::STATUS_W-1:0]  out_status_q;

	logic                          mod_done;
	logic [cda_pkg::MOD_W-1:0]     mod_rem;
	logic [cda_pkg::DAY_W-1:0]     cand_len;
	logic                          cand_ok;
	logic [cda_pkg::DAY_W-1:0]     w_len;
	logic                          month_end;
	logic                          w_year_max;
	logic                          leap_between;
	logic [cda_pkg::YEAR_LEN_W-1:0] year_len;

	cda_mod400 #(
		.YEAR_BITS(YEAR_BITS)
	) u_mod400 (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.mod_start),
		.value (new_year),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	assign cand_len = cda_pkg::month_len(cda_pkg::leap_of_mod(mod_rem), cand_mon_q);
	assign cand_ok  = (cand_year_q != '0) && (cand_len != '0) && (cand_day_q != '0) &&
		(cand_day_q <= cand_len);

	assign w_len      = cda_pkg::month_len(cda_pkg::leap_of_mod(w_mod_q), w_mon_q);
	assign month_end  = (w_day_q >= w_len);
	assign w_year_max = (w_year_q == '1);

	// A leap day lies within the next year when the date is before March of a leap
	// year, or from March on when the following year is a leap year.
	assign leap_between = (w_mon_q <= cda_pkg::MONTH_FEB) ?
		cda_pkg::leap_of_mod(w_mod_q) : cda_pkg::leap_of_mod(cda_pkg::mod_inc(w_mod_q));
	assign year_len = leap_between ? cda_pkg::YEAR_LEN_W'(cda_pkg::DAYS_LEAP_YEAR) :
		cda_pkg::YEAR_LEN_W'(cda_pkg::DAYS_YEAR);

	assign stat.mod_done  = mod_done;
	assign stat.n_zero    = (n_q == '0);
	assign stat.n_ge_year = (CMP_W'(n_q) >= CMP_W'(cda_pkg::DAYS_LEAP_YEAR));
	assign stat.feb29     = (w_mon_q == cda_pkg::MONTH_FEB) &&
		(w_day_q == cda_pkg::DAY_W'(cda_pkg::FEB_LEAP_DAYS));
	assign stat.year_max  = w_year_max;
	assign stat.day_ovf   = month_end && (w_mon_q >= cda_pkg::MONTH_DEC) && w_year_max;

	// Stored date: January 1 of year 1 after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_year_q <= YEAR_BITS'(1);
			date_mon_q  <= cda_pkg::MONTH_JAN;
			date_day_q  <= cda_pkg::DAY_FIRST;
			date_mod_q  <= cda_pkg::MOD_W'(1);
		end else if (ctl.set_check && cand_ok) begin
			date_year_q <= cand_year_q;
			date_mon_q  <= cand_mon_q;
			date_day_q  <= cand_day_q;
			date_mod_q  <= mod_rem;
		end else if (ctl.commit) begin
			date_year_q <= w_year_q;
			date_mon_q  <= w_mon_q;
			date_day_q  <= w_day_q;
			date_mod_q  <= w_mod_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cand_year_q <= new_year;
			cand_mon_q  <= new_month;
			cand_day_q  <= new_day;
			w_year_q    <= date_year_q;
			w_mon_q     <= date_mon_q;
			w_day_q     <= date_day_q;
			w_mod_q     <= date_mod_q;
			n_q         <= day_count;
		end else if (ctl.year_step) begin
			w_year_q <= w_year_q + YEAR_BITS'(1);
			w_mod_q  <= cda_pkg::mod_inc(w_mod_q);
			n_q      <= n_q - COUNT_BITS'(year_len);
		end else if (ctl.day_step) begin
			n_q <= n_q - COUNT_BITS'(1);
			if (month_end) begin
				w_day_q <= cda_pkg::DAY_FIRST;
				if (w_mon_q >= cda_pkg::MONTH_DEC) begin
					w_mon_q  <= cda_pkg::MONTH_JAN;
					w_year_q <= w_year_q + YEAR_BITS'(1);
					w_mod_q  <= cda_pkg::mod_inc(w_mod_q);
				end else begin
					w_mon_q <= w_mon_q + cda_pkg::MON_W'(1);
				end
			end else begin
				w_day_q <= w_day_q + cda_pkg::DAY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.set_check) begin
			res_status_q <= cand_ok ? cda_pkg::ST_OK : cda_pkg::ST_INVALID;
		end else if (ctl.commit) begin
			res_status_q <= cda_pkg::ST_OK;
		end else if (ctl.overflow) begin
			res_status_q <= cda_pkg::ST_OVERFLOW;
		end
		if (ctl.out_load) begin
			out_year_q   <= date_year_q;
			out_mon_q    <= date_mon_q;
			out_day_q    <= date_day_q;
			out_status_q <= res_status_q;
		end
	end

	assign cur_year  = out_year_q;
	assign cur_month = out_mon_q;
	assign cur_day   = out_day_q;
	assign status    = out_status_q;

endmodule

FILE: hdl/cda_ctrl.sv
// Controller state machine of the calendar date advance core: sequences set and add
// commands and owns the input and output handshakes. Depends on cda_pkg.
module cda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                item_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output cda_pkg::cda_cmd_t   ctl,
	input  cda_pkg::cda_stat_t  stat
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SET_MOD  = 3'd1;
	localparam logic [2:0] S_SET_CHK  = 3'd2;
	localparam logic [2:0] S_ADD_INIT = 3'd3;
	localparam logic [2:0] S_ADD_YEAR = 3'd4;
	localparam logic [2:0] S_ADD_DAY  = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load      = 1'b1;
					ctl.mod_start = (item_cmd == cda_pkg::CMD_SET);
					state_d       = (item_cmd == cda_pkg::CMD_ADD) ? S_ADD_INIT : S_SET_MOD;
				end
			end
			S_SET_MOD: begin
				if (stat.mod_done) begin
					state_d = S_SET_CHK;
				end
			end
			S_SET_CHK: begin
				ctl.set_check = 1'b1;
				state_d       = S_DONE;
			end
			S_ADD_INIT: begin
				// Leaving February 29 first keeps the whole-year steps on a date that
				// exists in every year.
				ctl.day_step = !stat.n_zero && stat.feb29;
				state_d      = S_ADD_YEAR;
			end
			S_ADD_YEAR: begin
				if (!stat.n_ge_year) begin
					state_d = S_ADD_DAY;
				end else if (stat.year_max) begin
					ctl.overflow = 1'b1;
					state_d      = S_DONE;
				end else begin
					ctl.year_step = 1'b1;
				end
			end
			S_ADD_DAY: begin
				if (stat.n_zero) begin
					ctl.commit = 1'b1;
					state_d    = S_DONE;
				end else if (stat.day_ovf) begin
					ctl.overflow = 1'b1;
					state_d      = S_DONE;
				end else begin
					ctl.day_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: hdl/calendar_date_advance_core.sv
// Top level of the calendar date advance core: controller plus datapath.
// Depends on cda_pkg, cda_ctrl, cda_dp and cda_mod400.
//
// The core holds one Gregorian date, January 1 of year 1 after reset, and takes one
// command per input transfer. A set command (cmd 0) checks new_year, new_month and
// new_day against the month lengths and the leap-year rule and stores the date only if
// it is valid; otherwise the date is kept and status reports an invalid date. An add
// command (cmd 1) advances the date by day_count days, first a whole year at a time
// while at least 366 days remain, then one day at a time; if the year would carry past
// its largest value the date is kept and status reports an overflow. Each command gives
// exactly one output transfer with the stored date and the status. One command is in
// work at a time. A set command reduces the year modulo 400 by a reciprocal
// multiplication, then checks the date, then loads the result once the output register
// is free. An add command first steps off February 29 if the date is on it and days
// remain, then takes whole-year steps and then single-day steps; the date datapath
// does one year or one day step per cycle while it steps.
// A finished result waits in the output register, and the next command is taken while
// it waits.
module calendar_date_advance_core #(
	parameter int YEAR_BITS  = cda_pkg::YEAR_BITS_DEF,
	parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [YEAR_BITS-1:0]          new_year,
	input  logic [cda_pkg::MON_W-1:0]     new_month,
	input  logic [cda_pkg::DAY_W-1:0]     new_day,
	input  logic [COUNT_BITS-1:0]         day_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [YEAR_BITS-1:0]          cur_year,
	output logic [cda_pkg::MON_W-1:0]     cur_month,
	output logic [cda_pkg::DAY_W-1:0]     cur_day,
	output logic [cda_pkg::STATUS_W-1:0]  status
);

	// Commands to the datapath and its status back to the controller.
	cda_pkg::cda_cmd_t  ctl;
	cda_pkg::cda_stat_t stat;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_cmd (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctl      (ctl),
		.stat     (stat)
	);

	// The datapath captures the transfer's fields when the controller issues a load and
	// keeps the output register stable until the controller loads the next result.
	cda_dp #(
		.YEAR_BITS (YEAR_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.new_year (new_year),
		.new_month(new_month),
		.new_day  (new_day),
		.day_count(day_count),
		.cur_year (cur_year),
		.cur_month(cur_month),
		.cur_day  (cur_day),
		.status   (status)
	);

endmodule

FILE: hdl/cda_checker.sv
// Port-level checker for the calendar date advance core, attached by bind.
// Depends on cda_pkg and calendar_date_advance_core.
module cda_checker #(
	parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [YEAR_BITS-1:0]          cur_year,
	input logic [cda_pkg::MON_W-1:0]     cur_month,
	input logic [cda_pkg::DAY_W-1:0]     cur_day,
	input logic [cda_pkg::STATUS_W-1:0]  status
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cur_year) &&
		$stable(cur_month) && $stable(cur_day) && $stable(status))
		else $error("result changed while stalled");

	// One command is in work at a time.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a command is in work");

	// A valid result has a nonzero year, a month from 1 to 12 and a nonzero day.
	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cur_year != '0) && (cur_month >= cda_pkg::MONTH_JAN) &&
		(cur_month <= cda_pkg::MONTH_DEC) && (cur_day != '0))
		else $error("result date out of range");

	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == cda_pkg::ST_OK) || (status == cda_pkg::ST_INVALID) ||
		(status == cda_pkg::ST_OVERFLOW))
		else $error("unknown status code");

endmodule

bind calendar_date_advance_core cda_checker #(
	.YEAR_BITS(YEAR_BITS)
) u_cda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.cur_year (cur_year),
	.cur_month(cur_month),
	.cur_day  (cur_day),
	.status   (status)
);

FILE: tb/tb_calendar_date_advance_core.sv
// Self-checking testbench for calendar_date_advance_core: directed and random set and add commands.
// A queue-fed driver, a monitor and an in-bench calendar predictor check every output transfer.
// Depends on cda_pkg and calendar_date_advance_core.
`timescale 1ns / 1ps

module tb_calendar_date_advance_core;

	localparam int YEAR_W  = cda_pkg::YEAR_BITS_DEF;
	localparam int COUNT_W = cda_pkg::COUNT_BITS_DEF;

	// Largest year and largest day count that the ports can carry.
	localparam int unsigned YEAR_TOP  = (1 << YEAR_W) - 1;
	localparam int unsigned COUNT_TOP = (1 << COUNT_W) - 1;

	typedef struct packed {
		logic [YEAR_W-1:0]         year;
		logic [cda_pkg::MON_W-1:0] month;
		logic [cda_pkg::DAY_W-1:0] day;
	} cal_date_t;

	// One command as it goes over the input channel.
	typedef struct packed {
		logic                      cmd;
		logic [YEAR_W-1:0]         year;
		logic [cda_pkg::MON_W-1:0] month;
		logic [cda_pkg::DAY_W-1:0] day;
		logic [COUNT_W-1:0]        count;
	} cal_cmd_t;

	// One result as it comes over the output channel.
	typedef struct packed {
		cal_date_t                    date;
		logic [cda_pkg::STATUS_W-1:0] status;
	} cal_result_t;

	logic                         clk;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic                         cmd        = cda_pkg::CMD_SET;
	logic [YEAR_W-1:0]            new_year   = '0;
	logic [cda_pkg::MON_W-1:0]    new_month  = '0;
	logic [cda_pkg::DAY_W-1:0]    new_day    = '0;
	logic [COUNT_W-1:0]           day_count  = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [YEAR_W-1:0]            cur_year;
	logic [cda_pkg::MON_W-1:0]    cur_month;
	logic [cda_pkg::DAY_W-1:0]    cur_day;
	logic [cda_pkg::STATUS_W-1:0] status;

	// Commands waiting to be driven, and the results the predictor expects, oldest first.
	cal_cmd_t    cmd_queue[$];
	cal_result_t expected_dates[$];

	// The predictor's copy of the stored date; January 1 of year 1 after reset.
	cal_date_t   cal_state = '{year: 1, month: 1, day: 1};

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches     = 0;

	calendar_date_advance_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.new_year  (new_year),
		.new_month (new_month),
		.new_day   (new_day),
		.day_count (day_count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cur_year  (cur_year),
		.cur_month (cur_month),
		.cur_day   (cur_day),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: a hung core or a lost transfer ends the run here.
	initial begin
		#40ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------

	// Gregorian rule: every fourth year, except centuries not divisible by 400.
	function automatic bit is_leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % cda_pkg::CENTURY != 0) || (y % cda_pkg::YEAR_CYCLE == 0));
	endfunction

	// Days in a month of a given year; zero marks a month number that does not exist.
	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		int unsigned n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11:           n = 30;
			2:                     n = is_leap_year(y) ? cda_pkg::FEB_LEAP_DAYS :
				cda_pkg::FEB_DAYS;
			default:               n = 0;
		endcase
		return n;
	endfunction

	// Moves the date on by one day. Returns 0 when the year would roll past its top value.
	function automatic bit next_day(inout cal_date_t dt);
		if (dt.day >= month_days(32'(dt.year), 32'(dt.month))) begin
			if (dt.month >= cda_pkg::MONTH_DEC) begin
				if (dt.year == YEAR_W'(YEAR_TOP))
					return 1'b0;
				dt.year  = dt.year + 1'b1;
				dt.month = cda_pkg::MONTH_JAN;
			end else begin
				dt.month = dt.month + 1'b1;
			end
			dt.day = cda_pkg::DAY_FIRST;
		end else begin
			dt.day = dt.day + 1'b1;
		end
		return 1'b1;
	endfunction

	// Adds n days: the leap-day start first, then whole years, then single days.
	// Returns 0 on year overflow; the caller then discards the working date.
	function automatic bit add_days_to(inout cal_date_t dt, input int unsigned n);
		bit leap_gap;
		if (n >= 1 && dt.month == cda_pkg::MONTH_FEB && dt.day == cda_pkg::FEB_LEAP_DAYS) begin
			if (!next_day(dt))
				return 1'b0;
			n = n - 1;
		end
		while (n >= cda_pkg::DAYS_LEAP_YEAR) begin
			// The leap day that matters is the one of this year if we are still
			// before March, otherwise the one of next year.
			leap_gap = (dt.month <= cda_pkg::MONTH_FEB) ? is_leap_year(32'(dt.year)) :
				is_leap_year(32'(dt.year) + 32'd1);
			if (dt.year == YEAR_W'(YEAR_TOP))
				return 1'b0;
			n = n - (leap_gap ? cda_pkg::DAYS_LEAP_YEAR : cda_pkg::DAYS_YEAR);
			dt.year = dt.year + 1'b1;
		end
		while (n > 0) begin
			if (!next_day(dt))
				return 1'b0;
			n = n - 1;
		end
		return 1'b1;
	endfunction

	// Applies one accepted command to the predictor state and queues the result it must give.
	task automatic predict_command(input cal_cmd_t c);
		cal_result_t r;
		cal_date_t   work;
		r.status = cda_pkg::ST_OK;
		if (c.cmd == cda_pkg::CMD_SET) begin
			// Year zero, a month outside 1 to 12 (length zero) and day zero all fail here.
			if (c.year == 0 || c.day == 0 || c.day > month_days(32'(c.year), 32'(c.month)))
				r.status = cda_pkg::ST_INVALID;
			else
				cal_state = '{year: c.year, month: c.month, day: c.day};
		end else begin
			work = cal_state;
			if (add_days_to(work, 32'(c.count)))
				cal_state = work;
			else
				r.status = cda_pkg::ST_OVERFLOW;
		end
		r.date = cal_state;
		expected_dates.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Input side: the driver takes commands from cmd_queue. An item is
	// predicted at the edge where its transfer happens, so the predictor
	// sees commands in exactly the order the core accepts them.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		cal_cmd_t next_cmd;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_command('{cmd: cmd, year: new_year, month: new_month,
					day: new_day, count: day_count});
			// The payload may only change once the current item is gone.
			if (!in_valid || in_ready) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd  = cmd_queue.pop_front();
					in_valid  <= 1'b1;
					cmd       <= next_cmd.cmd;
					new_year  <= next_cmd.year;
					new_month <= next_cmd.month;
					new_day   <= next_cmd.day;
					day_count <= next_cmd.count;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output side: every result transfer is compared with the oldest
	// expectation. The receiver stalls at random through out_ready.
	// ------------------------------------------------------------------

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_proc
		cal_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					report_mismatch("result transfer with nothing expected", 32'(cur_year),
						32'd0);
				end else begin
					want = expected_dates.pop_front();
					if (cur_year !== want.date.year)
						report_mismatch("cur_year", 32'(cur_year), 32'(want.date.year));
					if (cur_month !== want.date.month)
						report_mismatch("cur_month", 32'(cur_month), 32'(want.date.month));
					if (cur_day !== want.date.day)
						report_mismatch("cur_day", 32'(cur_day), 32'(want.date.day));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// A set command; the day count is ignored by the core, so it carries noise.
	task automatic queue_set(input int unsigned y, input int unsigned m, input int unsigned d);
		cmd_queue.push_back('{cmd: cda_pkg::CMD_SET, year: YEAR_W'(y),
			month: cda_pkg::MON_W'(m), day: cda_pkg::DAY_W'(d), count: COUNT_W'($urandom)});
	endtask

	// An add command; the date fields are ignored by the core, so they carry noise.
	task automatic queue_add(input int unsigned n);
		cmd_queue.push_back('{cmd: cda_pkg::CMD_ADD, year: YEAR_W'($urandom),
			month: cda_pkg::MON_W'($urandom), day: cda_pkg::DAY_W'($urandom),
			count: COUNT_W'(n)});
	endtask

	// A valid date, biased towards the top of the year range, year-end days and leap days.
	function automatic cal_date_t random_valid_date();
		cal_date_t   dt;
		int unsigned pick;
		int unsigned y;
		pick = $urandom_range(4);
		case (pick)
			0:       y = $urandom_range(YEAR_TOP, YEAR_TOP - 200);
			1:       y = $urandom_range(3000, 1);
			default: y = $urandom_range(YEAR_TOP, 1);
		endcase
		dt.year  = YEAR_W'(y);
		dt.month = cda_pkg::MON_W'($urandom_range(12, 1));
		dt.day   = cda_pkg::DAY_W'($urandom_range(month_days(32'(dt.year), 32'(dt.month)), 1));
		if (pick == 3) begin
			// February 29 of a leap year; a non-leap century falls back four years.
			y = 4 * $urandom_range((YEAR_TOP / 4), 1);
			if (!is_leap_year(y))
				y = y - 4;
			dt = '{year: YEAR_W'(y), month: cda_pkg::MONTH_FEB,
				day: cda_pkg::DAY_W'(cda_pkg::FEB_LEAP_DAYS)};
		end else if (pick == 4) begin
			// Late December of the last year, where adds run into the overflow.
			dt = '{year: YEAR_W'(YEAR_TOP), month: cda_pkg::MONTH_DEC,
				day: cda_pkg::DAY_W'($urandom_range(31, 20))};
		end
		return dt;
	endfunction

	// Mostly adds with small counts so the run stays short, a share of valid sets,
	// some sets with raw random fields (a share of them invalid) and a few huge counts.
	task automatic queue_random_command();
		int unsigned pick;
		int unsigned n;
		cal_date_t   dt;
		pick = $urandom_range(99);
		if (pick < 30) begin
			dt = random_valid_date();
			queue_set(32'(dt.year), 32'(dt.month), 32'(dt.day));
		end else if (pick < 38) begin
			queue_set($urandom_range(YEAR_TOP), $urandom_range(15), $urandom_range(31));
		end else begin
			pick = $urandom_range(99);
			if (pick < 50)
				n = $urandom_range(40);
			else if (pick < 75)
				n = $urandom_range(800);
			else if (pick < 90)
				n = $urandom_range(20000);
			else if (pick < 97)
				n = $urandom & COUNT_TOP;
			else if (pick == 97)
				n = 0;
			else
				n = COUNT_TOP;
			queue_add(n);
		end
	endtask

	// Holds the stimulus back until every queued command has gone and every
	// expected result has come back.
	task automatic wait_all_done();
		while (cmd_queue.size() > 0 || in_valid || expected_dates.size() > 0)
			@(posedge clk);
	endtask

	// One random phase with its own idling mix; knobs and queue change away
	// from the rising edge so that the driver never races with them.
	task automatic run_random_phase(input int unsigned n, input int unsigned send_pct,
		input int unsigned recv_pct);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (n)
			queue_random_command();
		wait_all_done();
	endtask

	initial begin : stimulus_proc
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, run without idling.
		queue_add(0);                               // reset date, nothing to add
		queue_add(1);                               // January 2 of year 1
		queue_set(0, 0, 0);                         // year zero is invalid
		queue_set(2023, 2, 29);                     // leap day in a common year
		queue_set(1900, 2, 29);                     // leap day in a non-leap century
		queue_set(2024, 13, 1);                     // month past December
		queue_set(2024, 4, 31);                     // day past a 30-day month
		queue_set(2024, 1, 0);                      // day zero
		queue_set(YEAR_TOP, 15, 31);                // all field bits high, invalid month
		queue_set(2000, 2, 29);                     // leap day in a 400-year century
		queue_add(0);                               // start on a leap day, zero count
		queue_add(1);                               // start on a leap day, one day on
		queue_set(2024, 2, 29);
		queue_add(366);                             // leap-day start, then a full year
		queue_set(2024, 2, 29);
		queue_add(COUNT_TOP);                       // largest count from a leap day
		queue_set(YEAR_TOP, 12, 31);
		queue_add(0);                               // last day, nothing to add
		queue_add(1);                               // one day past the last day overflows
		queue_set(YEAR_TOP, 3, 1);
		queue_add(400);                             // a whole-year step overflows
		queue_set(YEAR_TOP - 1, 12, 31);
		queue_add(1);                               // carries into the last year
		queue_set(1, 1, 1);
		queue_add(COUNT_TOP);                       // largest count from the first date
		wait_all_done();

		run_random_phase(40, 0, 0);
		run_random_phase(40, 74, 0);
		run_random_phase(40, 0, 74);
		run_random_phase(40, 24, 24);

		// Any stray result transfer would show up in this window.
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/cda_pkg.sv
hdl/cda_mod400.sv
hdl/cda_dp.sv
hdl/cda_ctrl.sv
hdl/calendar_date_advance_core.sv
hdl/cda_checker.sv
tb/tb_calendar_date_advance_core.sv
